>>> hw/rtl/baro_pkg.sv
// Shared types and constants for the barometric compensation and Kalman block.
package baro_pkg;

    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [23:0] raw_temperature;
    } baro_in_t;

    typedef struct packed {
        logic signed [14:0] temperature_tenths;
        logic signed [23:0] compensated_pressure;
        logic signed [23:0] filtered_pressure;
        logic [23:0]        error_covariance;
        logic               pressure_valid;
    } baro_out_t;

    // Register indexes
    localparam logic [2:0] REG_SENS        = 3'd0;
    localparam logic [2:0] REG_OFFSET      = 3'd1;
    localparam logic [2:0] REG_SENS_TC     = 3'd2;
    localparam logic [2:0] REG_OFFSET_TC   = 3'd3;
    localparam logic [2:0] REG_REF_TEMP    = 3'd4;
    localparam logic [2:0] REG_TEMP_COEFF  = 3'd5;
    localparam logic [2:0] REG_PROC_NOISE  = 3'd6;
    localparam logic [2:0] REG_SENS_NOISE  = 3'd7;

    localparam logic [23:0] COV_RESET = 24'd1281884;
    localparam logic [23:0] Q_RESET   = 24'd32768;

    // ceil(2^22 / 10): exact divide by ten for magnitudes below 2^18
    localparam logic [18:0] TENTH_RECIP = 19'd419431;

    // Serial multiplier operation codes
    localparam logic [1:0] MUL_SIGNED_B = 2'd0;
    localparam logic [1:0] MUL_UNSIGNED = 2'd1;

    typedef struct packed {
        logic start;
        logic b_signed;
    } baro_mul_ctl_t;

endpackage

>>> hw/rtl/baro_mul_serial.sv
// Bit-serial shift-add multiplier: unsigned a times (signed or unsigned) b.
module baro_mul_serial
    import baro_pkg::*;
#(
    parameter int AW = 48,
    parameter int BW = 26
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  baro_mul_ctl_t            ctl,
    input  logic [AW-1:0]            a,
    input  logic [BW-1:0]            b,
    output logic                     done,
    output logic signed [AW+BW:0]    prod
);
    localparam int CW = $clog2(BW + 1);

    logic [AW+BW:0] acc_reg, acc_next;
    logic [BW-1:0]  b_reg, b_next;
    logic [AW-1:0]  a_reg;
    logic           sgn_reg;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [AW+BW:0] addend;

    // one bit of b per cycle, LSB first; top bit of a signed b subtracts
    always_comb begin
        addend    = {{(BW+1){1'b0}}, a_reg} << cnt_reg;
        acc_next  = acc_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start) begin
            acc_next  = '0;
            b_next    = b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                if (sgn_reg && (cnt_reg == CW'(BW - 1))) begin
                    acc_next = acc_reg - addend;
                end else begin
                    acc_next = acc_reg + addend;
                end
            end
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(BW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        b_reg   <= b_next;
        if (ctl.start) begin
            a_reg   <= a;
            sgn_reg <= ctl.b_signed;
        end
    end

    assign done = done_reg;
    assign prod = $signed(acc_reg);

endmodule

>>> hw/rtl/baro_div_serial.sv
// Restoring divider, one quotient bit per cycle (unsigned).
module baro_div_serial #(
    parameter int NW = 40,
    parameter int DW = 40
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [DW:0]   rem_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    always_comb begin
        trial = {rem_reg[DW-1:0], q_reg[NW-1]};
        diff  = trial - {1'b0, d_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
        if (start) begin
            q_reg   <= num;
            rem_reg <= '0;
            d_reg   <= den;
        end else if (busy_reg) begin
            if (!diff[DW]) begin
                rem_reg <= diff;
                q_reg   <= {q_reg[NW-2:0], 1'b1};
            end else begin
                rem_reg <= trial;
                q_reg   <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

>>> hw/rtl/baro_compensate_and_kalman_smooth.sv
// Top level: barometric compensation followed by a scalar Kalman smoother.
//
// Usage:
//   s_valid/s_ready/s_data carry one beat of raw pressure (D1) and raw
//   temperature (D2). m_valid/m_ready/m_data return one beat per input with
//   temperature in tenths, compensated and filtered pressure, covariance and
//   a valid flag. The user must write calibration and noise registers via
//   cfg_we/cfg_index/cfg_data only while idle; the block has no such check.
// Sequencing:
//   One beat at a time. A sequencer drives one shared bit-serial multiplier
//   (26 multiplier bits) six times and one restoring divider (41 quotient
//   bits) once. m_valid rises when the result enters the output register
//   and s_ready rises with it, so the next beat is accepted only once the
//   previous result has been loaded.
// Stalls:
//   While m_ready is low the output register holds the result; the next beat
//   is still accepted and waits in the last step until the register is free.
// Reset:
//   aresetn (synchronous, active low) clears calibration words, sets the
//   process noise to 0.5 and the covariance to 19.56, and unprimes the filter.
module baro_compensate_and_kalman_smooth
    import baro_pkg::*;
#(
    parameter int PRESSURE_EXTRA_BITS = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  baro_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output baro_out_t   m_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    localparam int PSH = 15 - PRESSURE_EXTRA_BITS;

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_TEMP  = 4'd1;
    localparam logic [3:0] ST_OFF   = 4'd2;
    localparam logic [3:0] ST_SENS  = 4'd3;
    localparam logic [3:0] ST_X     = 4'd4;
    localparam logic [3:0] ST_DIV   = 4'd5;
    localparam logic [3:0] ST_EST   = 4'd6;
    localparam logic [3:0] ST_COV   = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    // configuration registers
    logic [15:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg, r_reg;
    logic [23:0] q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg <= '0; c2_reg <= '0; c3_reg <= '0; c4_reg <= '0;
            c5_reg <= '0; c6_reg <= '0; r_reg <= '0;
            q_reg  <= Q_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SENS:       c1_reg <= cfg_data[15:0];
                REG_OFFSET:     c2_reg <= cfg_data[15:0];
                REG_SENS_TC:    c3_reg <= cfg_data[15:0];
                REG_OFFSET_TC:  c4_reg <= cfg_data[15:0];
                REG_REF_TEMP:   c5_reg <= cfg_data[15:0];
                REG_TEMP_COEFF: c6_reg <= cfg_data[15:0];
                REG_PROC_NOISE: q_reg  <= cfg_data;
                REG_SENS_NOISE: r_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // datapath registers
    logic [3:0]          st_reg;
    logic [23:0]         d1_reg;
    logic signed [24:0]  dt_reg;
    logic signed [47:0]  off_reg;
    logic signed [47:0]  sens_reg;
    logic signed [24:0]  pc_reg;
    logic                pvalid_reg;
    logic [24:0]         p1_reg;
    logic [16:0]         k_reg;
    logic signed [39:0]  est_reg;
    logic [23:0]         cov_reg;
    logic                primed_reg;
    logic                out_valid_reg;
    baro_out_t           out_reg;
    logic signed [14:0]  tenths_reg;
    logic signed [18:0]  t100_reg;
    logic signed [23:0]  filt_reg;

    // shared multiplier: a is unsigned up to 48 bits, b signed/unsigned 26 bits
    localparam int AW = 48;
    localparam int BW = 26;
    baro_mul_ctl_t       mctl;
    logic [AW-1:0]       ma;
    logic [BW-1:0]       mb;
    logic                mdone;
    logic signed [AW+BW:0] mprod;
    logic                mstart_reg;
    logic                dstart_reg;
    logic                ddone;
    logic [40:0]         dquot;
    logic [40:0]         dden;
    logic [AW-1:0]       ma_sel;
    logic [BW-1:0]       mb_sel;

    baro_mul_serial #(.AW(AW), .BW(BW)) u_mul (
        .aclk, .aresetn, .ctl(mctl), .a(ma_sel), .b(mb_sel), .done(mdone), .prod(mprod)
    );

    assign dden = 41'(p1_reg) + {9'd0, r_reg, 16'd0};

    baro_div_serial #(.NW(41), .DW(41)) u_div (
        .aclk, .aresetn, .start(dstart_reg), .num({p1_reg, 16'd0}),
        .den(dden), .done(ddone), .quot(dquot)
    );

    // operand selection per step
    logic signed [40:0] diff;
    logic signed [39:0] mval;
    always_comb begin
        mval = {pc_reg[23:0], 16'd0};
        diff = primed_reg ? (41'(mval) - 41'(est_reg)) : 41'sd0;
        ma = '0;
        mb = '0;
        mctl.start    = mstart_reg;
        mctl.b_signed = 1'b1;
        unique case (st_reg)
            ST_TEMP: begin ma = AW'(c6_reg); mb = BW'(dt_reg); end
            ST_OFF:  begin ma = AW'(c4_reg); mb = BW'(dt_reg); end
            ST_SENS: begin ma = AW'(c3_reg); mb = BW'(dt_reg); end
            ST_X:    begin ma = AW'(d1_reg); mb = BW'(0); end
            ST_EST:  begin ma = AW'(k_reg); mb = BW'(0); end
            ST_COV:  begin
                ma = AW'(p1_reg);
                mb = BW'(17'd65536 - k_reg);
                mctl.b_signed = 1'b0;
            end
            default: ;
        endcase
    end

    // X and estimate products need signed wide operands: handle via sign/magnitude
    logic [47:0] xmag;
    logic        xneg;
    logic [40:0] dmag;
    logic        dneg;
    logic signed [AW+BW:0] mprod_fix;
    always_comb begin
        xneg = sens_reg[47];
        xmag = xneg ? 48'(-sens_reg) : 48'(sens_reg);
        dneg = diff[40];
        dmag = dneg ? 41'(-diff) : 41'(diff);
        mprod_fix = mprod;
    end

    logic [AW-1:0] ma_x;
    logic [BW-1:0] mb_x;
    // long operands are mapped so that multiplier a carries the wide magnitude
    always_comb begin
        ma_x = '0; mb_x = '0;
        if (st_reg == ST_X) begin
            ma_x = xmag; mb_x = BW'(d1_reg);
        end else begin
            ma_x = 48'(dmag); mb_x = BW'(k_reg);
        end
        ma_sel = ((st_reg == ST_X) || (st_reg == ST_EST)) ? ma_x : ma;
        mb_sel = ((st_reg == ST_X) || (st_reg == ST_EST)) ? mb_x : mb;
    end

    // floor shift helpers on the product
    logic signed [AW+BW:0] prod_s;
    logic signed [AW+BW:0] prod_mag_signed;
    always_comb begin
        prod_s = mprod_fix;
        prod_mag_signed = (((st_reg == ST_X) && xneg) || ((st_reg == ST_EST) && dneg))
                        ? -mprod_fix : mprod_fix;
    end

    logic signed [63:0] t100;
    logic signed [63:0] xval;
    logic signed [63:0] pfl;
    logic signed [63:0] ptr;
    logic signed [63:0] estn;
    logic signed [63:0] filt;
    always_comb begin
        t100 = 64'sd2000 + 64'(prod_s >>> 23);
        xval = 64'(prod_mag_signed >>> 21) - 64'(off_reg);
        pfl  = xval >>> PSH;
        ptr  = (pfl < 0) ? -((-pfl) >>> PRESSURE_EXTRA_BITS) : (pfl >>> PRESSURE_EXTRA_BITS);
        estn = 64'(est_reg) + 64'(prod_mag_signed >>> 16);
        filt = (estn < 0) ? -((-estn) >>> 16) : (estn >>> 16);
    end

    // tenths: magnitude times reciprocal of ten, sign restored (toward zero)
    logic [17:0]        t_mag;
    logic [36:0]        t_scaled;
    logic [14:0]        t_quot;
    logic signed [14:0] tenths_calc;
    always_comb begin
        t_mag       = t100_reg[18] ? 18'(-t100_reg) : 18'(t100_reg);
        t_scaled    = 37'(t_mag) * 37'(TENTH_RECIP);
        t_quot      = t_scaled[36:22];
        tenths_calc = t100_reg[18] ? -$signed(t_quot) : $signed(t_quot);
    end

    logic [24:0] p1_sum;
    assign p1_sum = 25'(cov_reg) + 25'(q_reg);

    // result moves to the output register once the slot is free
    logic load_out;
    assign load_out = (st_reg == ST_OUT) && (!out_valid_reg || m_ready);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_IDLE;
            mstart_reg    <= 1'b0;
            dstart_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            primed_reg    <= 1'b0;
            est_reg       <= '0;
            cov_reg       <= COV_RESET;
        end else begin
            mstart_reg <= 1'b0;
            dstart_reg <= 1'b0;
            if (load_out) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
            unique case (st_reg)
                ST_IDLE: if (s_valid) begin
                    d1_reg <= s_data.raw_pressure;
                    dt_reg <= 25'(s_data.raw_temperature) - {1'b0, c5_reg, 8'd0};
                    p1_reg <= p1_sum[24] ? 25'hFFFFFF : p1_sum;
                    st_reg <= ST_TEMP;
                    mstart_reg <= 1'b1;
                end
                ST_TEMP: if (mdone) begin
                    t100_reg <= 19'(t100);
                    st_reg <= ST_OFF; mstart_reg <= 1'b1;
                end
                ST_OFF: if (mdone) begin
                    tenths_reg <= tenths_calc;
                    off_reg <= 48'({c2_reg, 16'd0}) + 48'(prod_s >>> 7);
                    st_reg <= ST_SENS; mstart_reg <= 1'b1;
                end
                ST_SENS: if (mdone) begin
                    sens_reg <= 48'({c1_reg, 15'd0}) + 48'(prod_s >>> 8);
                    st_reg <= ST_X; mstart_reg <= 1'b1;
                end
                ST_X: if (mdone) begin
                    pvalid_reg <= ptr > 0;
                    pc_reg <= (ptr > 64'sd8388607) ? 25'sd8388607 :
                              (ptr < -64'sd8388608) ? -25'sd8388608 : 25'(ptr);
                    st_reg <= ST_DIV; dstart_reg <= 1'b1;
                end
                ST_DIV: if (ddone) begin
                    k_reg <= (dden == '0) ? 17'd65536 : 17'(dquot);
                    if (!primed_reg) begin
                        est_reg <= mval;
                        primed_reg <= 1'b1;
                    end
                    st_reg <= ST_EST; mstart_reg <= 1'b1;
                end
                ST_EST: if (mdone) begin
                    est_reg <= 40'(estn);
                    filt_reg <= (filt > 64'sd8388607) ? 24'sh7FFFFF :
                        (filt < -64'sd8388608) ? 24'sh800000 : 24'(filt);
                    st_reg <= ST_COV; mstart_reg <= 1'b1;
                end
                ST_COV: if (mdone) begin
                    cov_reg <= 24'(mprod >>> 16);
                    st_reg <= ST_OUT;
                end
                ST_OUT: if (load_out) begin
                    out_reg.temperature_tenths   <= tenths_reg;
                    out_reg.compensated_pressure <= pc_reg[23:0];
                    out_reg.filtered_pressure    <= filt_reg;
                    out_reg.error_covariance     <= cov_reg;
                    out_reg.pressure_valid       <= pvalid_reg;
                    st_reg <= ST_IDLE;
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (st_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg != ST_IDLE) |-> !s_ready) else $error("accept while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");
    a_primed_after: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_EST) |-> primed_reg) else $error("estimate not primed");
`endif

endmodule

>>> dv/tb.sv
// Self-checking testbench for the barometric compensation and Kalman smoothing block.
module tb;
    import baro_pkg::*;

    localparam int EXTRA_BITS = 5;
    localparam int RANDOM_ITEMS = 850;
    localparam longint CYCLE_LIMIT = 3000000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    baro_in_t    s_data;
    logic        m_valid;
    logic        m_ready;
    baro_out_t   m_data;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;

    baro_compensate_and_kalman_smooth #(.PRESSURE_EXTRA_BITS(EXTRA_BITS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Shadow copies of the calibration and filter state
    logic [15:0] c_sens, c_off, c_sens_tc, c_off_tc, c_tref, c_tco, r_noise;
    logic [23:0] q_noise;
    longint      kal_est;
    logic [23:0] kal_cov;
    bit          kal_primed;

    baro_in_t  pending_beats[$];
    baro_out_t expected_results[$];

    int  send_idle_pct, recv_idle_pct;
    int  mismatches;
    int  beats_sent, results_seen, valid_results;
    longint cycles;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic longint floor_div_pow2(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp24(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    // Compute expected result and advance the filter state
    function automatic baro_out_t predict_reading(baro_in_t b);
        baro_out_t o;
        longint d1, d2, dt, t100, offs, sens, x, p, pc, m, diff;
        longint unsigned p1, den, k;
        d1 = longint'(b.raw_pressure);
        d2 = longint'(b.raw_temperature);
        dt = d2 - (longint'(c_tref) <<< 8);
        t100 = 2000 + floor_div_pow2(dt * longint'(c_tco), 23);
        offs = (longint'(c_off) <<< 16) + floor_div_pow2(longint'(c_off_tc) * dt, 7);
        sens = (longint'(c_sens) <<< 15) + floor_div_pow2(longint'(c_sens_tc) * dt, 8);
        x = floor_div_pow2(d1 * sens, 21) - offs;
        p = floor_div_pow2(x, 15 - EXTRA_BITS) / (64'sd1 <<< EXTRA_BITS);
        pc = clamp24(p);
        m = pc * 65536;
        if (!kal_primed) begin
            kal_est = m;
            kal_primed = 1'b1;
        end
        p1 = longint'(kal_cov) + longint'(q_noise);
        if (p1 > 64'hFFFFFF) p1 = 64'hFFFFFF;
        den = p1 + (longint'(r_noise) << 16);
        k = (den == 0) ? 64'd65536 : (p1 << 16) / den;
        diff = m - kal_est;
        kal_est = kal_est + floor_div_pow2(longint'(k) * diff, 16);
        kal_cov = 24'(((64'd65536 - k) * p1) >> 16);
        o.temperature_tenths = 15'(t100 / 10);
        o.compensated_pressure = 24'(pc);
        o.filtered_pressure = 24'(clamp24(kal_est / 65536));
        o.error_covariance = kal_cov;
        o.pressure_valid = (p > 0);
        return o;
    endfunction

    // Driver: present queued beats, idling at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) beats_sent <= beats_sent + 1;
            if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_data <= pending_beats[0];
                expected_results.push_back(predict_reading(pending_beats.pop_front()));
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: random stalls, compare each result beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (m_data.pressure_valid) valid_results <= valid_results + 1;
                if (expected_results.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected result beat %p", m_data);
                end else begin
                    if (m_data !== expected_results[0]) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: expected %p got %p",
                                     expected_results[0], m_data);
                    end
                    void'(expected_results.pop_front());
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Cycle limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SENS:       c_sens = val[15:0];
            REG_OFFSET:     c_off = val[15:0];
            REG_SENS_TC:    c_sens_tc = val[15:0];
            REG_OFFSET_TC:  c_off_tc = val[15:0];
            REG_REF_TEMP:   c_tref = val[15:0];
            REG_TEMP_COEFF: c_tco = val[15:0];
            REG_PROC_NOISE: q_noise = val;
            REG_SENS_NOISE: r_noise = val[15:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_beats.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_calibration(logic [15:0] s, logic [15:0] o, logic [15:0] stc,
                                   logic [15:0] otc, logic [15:0] tr, logic [15:0] tc,
                                   logic [23:0] q, logic [15:0] r);
        write_reg(REG_SENS, s);
        write_reg(REG_OFFSET, o);
        write_reg(REG_SENS_TC, stc);
        write_reg(REG_OFFSET_TC, otc);
        write_reg(REG_REF_TEMP, tr);
        write_reg(REG_TEMP_COEFF, tc);
        write_reg(REG_PROC_NOISE, q);
        write_reg(REG_SENS_NOISE, r);
    endtask

    function automatic baro_in_t make_beat(logic [23:0] p, logic [23:0] t);
        baro_in_t b;
        b.raw_pressure = p;
        b.raw_temperature = t;
        return b;
    endfunction

    // Realistic readings near the calibrated operating point, some full range
    function automatic baro_in_t random_reading();
        if ($urandom_range(9) < 7)
            return make_beat(24'($urandom_range(9500000, 8000000)),
                             24'($urandom_range(8900000, 7800000)));
        return make_beat(24'($urandom), 24'($urandom));
    endfunction

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_SENS;
        cfg_data = '0;
        mismatches = 0;
        beats_sent = 0;
        results_seen = 0;
        valid_results = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        c_sens = 0; c_off = 0; c_sens_tc = 0; c_off_tc = 0;
        c_tref = 0; c_tco = 0; r_noise = 0;
        q_noise = Q_RESET;
        kal_est = 0;
        kal_cov = COV_RESET;
        kal_primed = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset defaults: zero calibration, zero gain denominator never hit
        pending_beats.push_back(make_beat(24'd0, 24'd0));
        pending_beats.push_back(make_beat(24'hFFFFFF, 24'hFFFFFF));
        wait_drained();

        // Zero q and r: zero gain denominator
        set_calibration(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 24'd0, 16'd0);
        repeat (3) pending_beats.push_back(make_beat(24'h800000, 24'h123456));
        wait_drained();

        // Extremes: saturation high and low, covariance overflow
        set_calibration(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF,
                        24'hFFFFFF, 16'hFFFF);
        pending_beats.push_back(make_beat(24'hFFFFFF, 24'hFFFFFF));
        pending_beats.push_back(make_beat(24'hFFFFFF, 24'd0));
        pending_beats.push_back(make_beat(24'd1, 24'hFFFFFF));
        wait_drained();
        set_calibration(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        24'hFFFFFF, 16'd0);
        wait_drained();
        pending_beats.push_back(make_beat(24'd0, 24'd0));
        pending_beats.push_back(make_beat(24'hFFFFFF, 24'hFFFFFF));
        pending_beats.push_back(make_beat(24'h555555, 24'hAAAAAA));
        pending_beats.push_back(make_beat(24'hAAAAAA, 24'h555555));
        wait_drained();

        // Typical calibration; random traffic across three idling phases
        set_calibration(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33792,
                        16'd28312, 24'd32768, 16'd5);
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 74 : 0;
            recv_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 20 : 0;
            for (int i = 0; i < RANDOM_ITEMS / 3; i++)
                pending_beats.push_back(random_reading());
            wait_drained();
            // Fresh random calibration for the next phase
            set_calibration(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom_range(40000, 25000)), 16'($urandom),
                            24'($urandom_range(200000)), 16'($urandom_range(50)));
        end
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (300) @(posedge aclk);

        $display("Ran %0d beats, %0d results (%0d with positive pressure)",
                 beats_sent, results_seen, valid_results);
        $display("over reset, extreme and random calibrations with mixed stalls");
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/baro_pkg.sv
hw/rtl/baro_mul_serial.sv
hw/rtl/baro_div_serial.sv
hw/rtl/baro_compensate_and_kalman_smooth.sv
dv/tb.sv
